/* rtl/core/idea_pkg.sv */
// Shared types, constants and modular arithmetic for the IDEA cipher engine.
`default_nettype none

package idea_pkg;

  typedef logic [15:0] word_t;

  // Control bits that travel down the pipeline beside each beat.
  typedef struct packed {
    logic valid;
    logic dir;
  } ctl_t;

  localparam int NSUB       = 52;
  localparam int KEY_BITS   = 128;
  localparam int ROT_HI     = 9;
  localparam int KEY_ROT    = 16 + ROT_HI;
  localparam int INV_ITERS  = 16;
  localparam int ITER_W     = $clog2(INV_ITERS);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(INV_ITERS - 1);
  localparam logic [16:0] IDEA_MOD = 17'h10001;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;

  // Multiplication modulo 65537, word 0 standing for 65536.
  function automatic word_t mul_mod(input word_t a, input word_t b);
    logic [31:0] p;
    logic [16:0] diff;
    p = 32'(a) * 32'(b);
    diff = {1'b0, p[15:0]} - {1'b0, p[31:16]};
    if (p[15:0] < p[31:16]) begin
      diff = diff + IDEA_MOD;
    end
    if (p == 32'd0) begin
      return word_t'(16'd1 - a - b);
    end
    return diff[15:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/idea_round.sv */
// One IDEA round as three register stages.
`default_nettype none

module idea_round (
  input  logic               clk,
  input  logic               rst,
  input  idea_pkg::ctl_t     in_ctl,
  input  logic [63:0]        x,
  input  idea_pkg::word_t    kf [6],
  input  idea_pkg::word_t    ki [6],
  output idea_pkg::ctl_t     out_ctl,
  output logic [63:0]        y
);
  import idea_pkg::*;

  ctl_t  c1, c2, c3;
  word_t a1, b1, cc1, d1;
  word_t a2, b2, cc2, d2, t1_2;
  word_t a3, b3, cc3, d3, t1_3, t2_3;
  word_t k0, k1, k2, k3, k4, k5, sum;

  // Subkeys chosen by the direction carried in each stage.
  assign k0 = in_ctl.dir ? ki[0] : kf[0];
  assign k1 = in_ctl.dir ? ki[1] : kf[1];
  assign k2 = in_ctl.dir ? ki[2] : kf[2];
  assign k3 = in_ctl.dir ? ki[3] : kf[3];
  assign k4 = c1.dir ? ki[4] : kf[4];
  assign k5 = c2.dir ? ki[5] : kf[5];

  // Control bits (valid and direction) of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
    end else begin
      c1 <= in_ctl;
      c2 <= c1;
      c3 <= c2;
    end
  end

  // Stage one: key mixing; stage two: first MA multiply; stage three: second.
  always_ff @(posedge clk) begin
    a1   <= mul_mod(x[63:48], k0);
    b1   <= x[47:32] + k1;
    cc1  <= x[31:16] + k2;
    d1   <= mul_mod(x[15:0], k3);
    a2   <= a1;
    b2   <= b1;
    cc2  <= cc1;
    d2   <= d1;
    t1_2 <= mul_mod(a1 ^ cc1, k4);
    a3   <= a2;
    b3   <= b2;
    cc3  <= cc2;
    d3   <= d2;
    t1_3 <= t1_2;
    t2_3 <= mul_mod((b2 ^ d2) + t1_2, k5);
  end

  // Final mixing of the round.
  assign sum     = t1_3 + t2_3;
  assign y       = {a3 ^ t2_3, cc3 ^ t2_3, b3 ^ sum, d3 ^ sum};
  assign out_ctl = c3;

endmodule

`default_nettype wire

/* rtl/core/idea_block_cipher_top.sv */
// Top level of the IDEA cipher engine: key schedule, round pipeline, output transform.
//
//  channel   signals                          direction  notes
//  command   start, busy, req_type, block_in  in         beat taken when start && !busy
//  result    done, block_out                  out        one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_addr, cfg_wdata      in         key_high at 0, key_low at 1
//
// A beat enters every cycle while busy is low; each round is three stages, key mixing
// and the two MA multiplies, and the output transform one more.
// A key write runs the inverse schedule on one shared modular multiplier: 2*ROUNDS+2
// inversions, each a load step and 16 square-and-multiply iterations of three steps,
// with busy high throughout. Reset loads the schedule of the zero key at once.
`default_nettype none

module idea_block_cipher_top #(
  parameter int ROUNDS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [63:0] block_in,
  output logic        done,
  output logic [63:0] block_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);
  import idea_pkg::*;

  localparam int NKEY = 6 * ROUNDS + 4;
  localparam int NINV = 2 * ROUNDS + 2;
  localparam int JW   = $clog2(NINV);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_MUL0 = 5'b00100,
    S_MUL1 = 5'b01000,
    S_MUL2 = 5'b10000
  } state_t;

  state_t            state;
  logic [63:0]       key_high, key_low;
  logic [127:0]      key;
  logic              key_write;
  logic [JW-1:0]     j;
  logic [ITER_W-1:0] iter;
  logic [16:0]       rv, av, qm, red;
  logic [33:0]       prod;
  word_t             fwd [NKEY];
  word_t             inv [NKEY];
  word_t             inv_mul [NINV];
  word_t             inv_src [NINV];
  ctl_t              st_ctl [ROUNDS+1];
  logic [63:0]       st_x [ROUNDS+1];
  logic [63:0]       y;
  ctl_t              yc;
  word_t             o0, o1, o2, o3;

  assign key_write = cfg_we && (cfg_addr == REG_KEY_HIGH || cfg_addr == REG_KEY_LOW);
  assign busy      = (state != S_IDLE);
  assign key       = {key_high, key_low};

  // Key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we && cfg_addr == REG_KEY_HIGH) begin
      key_high <= cfg_wdata;
    end else if (cfg_we && cfg_addr == REG_KEY_LOW) begin
      key_low <= cfg_wdata;
    end
  end

  // Forward subkeys: fixed rotations of the key, eight words per group.
  for (genvar n = 0; n < NKEY; n++) begin : g_fwd
    localparam int ROT = (KEY_ROT * (n / 8)) % KEY_BITS;
    localparam int W   = n % 8;
    logic [127:0] rot;
    assign rot    = (key << ROT) | (key >> (KEY_BITS - ROT));
    assign fwd[n] = rot[KEY_BITS-1-16*W -: 16];
  end

  // Words that need a multiplicative inverse, in schedule order.
  for (genvar i = 0; i < NINV; i++) begin : g_src
    assign inv_src[i] = fwd[6 * (ROUNDS - i / 2) + 3 * (i % 2)];
  end

  // Inverse subkeys from the stored inverses, negations and copies.
  for (genvar r = 0; r <= ROUNDS; r++) begin : g_inv
    localparam int S  = 6 * (ROUNDS - r);
    localparam int SW = (r > 0 && r < ROUNDS) ? 1 : 0;
    assign inv[6*r+0] = inv_mul[2*r];
    assign inv[6*r+1] = word_t'(17'h10000 - {1'b0, fwd[S+1+SW]});
    assign inv[6*r+2] = word_t'(17'h10000 - {1'b0, fwd[S+2-SW]});
    assign inv[6*r+3] = inv_mul[2*r+1];
    if (r < ROUNDS) begin : g_ma
      assign inv[6*r+4] = fwd[6*(ROUNDS-1-r)+4];
      assign inv[6*r+5] = fwd[6*(ROUNDS-1-r)+5];
    end
  end

  // Reduction of the 34-bit product modulo 65537.
  always_comb begin
    qm = (prod[33:16] >= {1'b0, IDEA_MOD}) ? 17'(prod[33:16] - {1'b0, IDEA_MOD})
                                           : prod[32:16];
    if ({1'b0, prod[15:0]} >= qm) begin
      red = {1'b0, prod[15:0]} - qm;
    end else begin
      red = {1'b0, prod[15:0]} + IDEA_MOD - qm;
    end
  end

  // Inversion sequencer: square and multiply, x to the power 65535.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j     <= '0;
      iter  <= '0;
      for (int k = 0; k < NINV; k++) begin
        inv_mul[k] <= '0;
      end
    end else if (key_write) begin
      state <= S_LOAD;
      j     <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          iter  <= '0;
          state <= S_MUL0;
        end
        S_MUL0: state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: begin
          if (iter == ITER_LAST) begin
            inv_mul[j] <= rv[15:0];
            if (j == JW'(NINV - 1)) begin
              state <= S_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= S_LOAD;
            end
          end else begin
            iter  <= iter + 1'b1;
            state <= S_MUL0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sequencer datapath: one shared multiplier.
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        rv <= 17'd1;
        av <= {1'b0, inv_src[j]};
      end
      S_MUL0: prod <= 34'(rv) * 34'(av);
      S_MUL1: begin
        rv   <= red;
        prod <= 34'(av) * 34'(av);
      end
      S_MUL2: av <= red;
      default: ;
    endcase
  end

  // Round pipeline.
  assign st_ctl[0] = '{valid: start && !busy, dir: req_type};
  assign st_x[0]   = block_in;

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    word_t kf [6];
    word_t ki [6];
    for (genvar k = 0; k < 6; k++) begin : g_key
      assign kf[k] = fwd[6*i+k];
      assign ki[k] = inv[6*i+k];
    end
    idea_round u_round (
      .clk     (clk),
      .rst     (rst),
      .in_ctl  (st_ctl[i]),
      .x       (st_x[i]),
      .kf      (kf),
      .ki      (ki),
      .out_ctl (st_ctl[i+1]),
      .y       (st_x[i+1])
    );
  end

  // Output transform.
  assign y  = st_x[ROUNDS];
  assign yc = st_ctl[ROUNDS];
  assign o0 = yc.dir ? inv[6*ROUNDS+0] : fwd[6*ROUNDS+0];
  assign o1 = yc.dir ? inv[6*ROUNDS+1] : fwd[6*ROUNDS+1];
  assign o2 = yc.dir ? inv[6*ROUNDS+2] : fwd[6*ROUNDS+2];
  assign o3 = yc.dir ? inv[6*ROUNDS+3] : fwd[6*ROUNDS+3];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= yc.valid;
    end
  end

  always_ff @(posedge clk) begin
    block_out <= {mul_mod(y[63:48], o0), y[31:16] + o1, y[47:32] + o2,
                  mul_mod(y[15:0], o3)};
  end

  // Checks on the key schedule sequencer.
  a_write_busy: assert property (@(posedge clk) disable iff (rst) key_write |=> busy)
    else $error("key write did not start the schedule");

  a_load_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && !key_write) |=> state == S_MUL0)
    else $error("load step did not move to the first multiply");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL2 && iter == ITER_LAST && j == JW'(NINV - 1) && !key_write) |=> !busy)
    else $error("schedule did not finish after the last inversion");

endmodule

`default_nettype wire
